### rtl/core/radio_packet_sample_deframer_core_macros.svh
// Assertion helpers for the sample deframer core.
// Every check is sampled on the rising clock edge and is held off while reset is low.
`ifndef RADIO_PACKET_SAMPLE_DEFRAMER_CORE_MACROS_SVH
`define RADIO_PACKET_SAMPLE_DEFRAMER_CORE_MACROS_SVH

// Concurrent check with a fixed report text.
`define RPSD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rpsd core check failed");

// Concurrent check with a caller-supplied report text.
`define RPSD_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

### rtl/core/rpsd_pkg.sv
`timescale 1ns / 1ps
package rpsd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_CONTROL = 3'd1;
  localparam logic [2:0] KIND_IQ      = 3'd2;
  localparam logic [2:0] KIND_MIC     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_BAD_HEADER   = 2'd0;
  localparam logic [1:0] ERR_BAD_PKT_TYPE = 2'd1;
  localparam logic [1:0] ERR_BAD_ENDPOINT = 2'd2;
  localparam logic [1:0] ERR_SYNC         = 2'd3;

  // Configuration register indexes
  localparam logic CFG_RECEIVER_COUNT = 1'b0;
  localparam logic CFG_SYNC_BYTE      = 1'b1;

  localparam logic [3:0] RX_COUNT_RESET  = 4'd1;
  localparam logic [7:0] SYNC_BYTE_RESET = 8'd127;
  localparam logic [3:0] RX_COUNT_LIMIT  = 4'd8;

  // Header layout
  localparam int         HDR_BYTES       = 8;
  localparam logic [7:0] HDR_MAGIC0      = 8'hEF;
  localparam logic [7:0] HDR_MAGIC1      = 8'hFE;
  localparam logic [7:0] PKT_TYPE_DATA   = 8'd1;
  localparam logic [7:0] PKT_TYPE_DISC_A = 8'd2;
  localparam logic [7:0] PKT_TYPE_DISC_B = 8'd3;
  localparam logic [7:0] EP_SAMPLES      = 8'd6;
  localparam logic [7:0] EP_IGNORED      = 8'd4;

  // Sub-frame layout
  localparam int SYNC_BYTES      = 3;
  localparam int CTRL_LAST       = 7;
  localparam int GROUP_AREA_BASE = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic [7:0]         endpoint;
    logic [31:0]        sequence_number;
    logic [39:0]        control_bytes;
    logic [2:0]         receiver_index;
    logic signed [23:0] i_sample;
    logic signed [23:0] q_sample;
    logic signed [15:0] mic_sample;
    logic [1:0]         error_code;
    logic               halted;
  } out_item_t;

  // Group tracker control from the parser
  typedef struct packed {
    logic restart;
    logic advance;
  } lane_ctrl_t;

  // Group position of the current byte for the selected receiver count
  typedef struct packed {
    logic       in_group;
    logic       iq_done;
    logic       mic_done;
    logic [2:0] rx;
  } grp_info_t;

  // Parser status
  typedef struct packed {
    logic halted;
    logic drop_rest;
  } par_stat_t;

  // Bytes at the end of a sub-frame that carry no sample groups
  function automatic int usable_slack(input int rx_count);
    int slack;
    case (rx_count)
      3:       slack = 4;
      4:       slack = 10;
      5:       slack = 24;
      6:       slack = 10;
      7:       slack = 20;
      8:       slack = 4;
      default: slack = 0;
    endcase
    return slack;
  endfunction

  // Quotient by 6 for a 6-bit value (reciprocal 43/256 is exact below 64)
  function automatic logic [3:0] div6(input logic [5:0] val);
    logic [11:0] prod;
    prod = {6'd0, val} * 12'd43;
    return prod[11:8];
  endfunction

  function automatic logic [2:0] mod6(input logic [5:0] val);
    logic [3:0] quo;
    logic [5:0] mul;
    quo = div6(val);
    mul = {quo[3:0], 2'b00} + {1'b0, quo[3:0], 1'b0};
    return 3'(val - mul);
  endfunction

endpackage

### rtl/core/rpsd_group_lanes.sv
`timescale 1ns / 1ps
module rpsd_group_lanes #(
  parameter int SUBFRAME_BYTES = 512,
  parameter int MAX_RECEIVERS  = 8,
  parameter int SPW            = $clog2(SUBFRAME_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpsd_pkg::lane_ctrl_t ctrl_i,
  input  logic [3:0]          rx_count_i,
  output rpsd_pkg::grp_info_t  grp_o
);
  import rpsd_pkg::*;

  localparam int STW = SPW + 2;

  grp_info_t lane_info [MAX_RECEIVERS];

  // One tracker per receiver count, so a count change between bytes
  // finds its group position already known.
  for (genvar l = 1; l <= MAX_RECEIVERS; l++) begin : g_lane
    localparam int GS = 6 * l + 2;
    localparam logic [STW-1:0] GS_V     = STW'(GS);
    localparam logic [STW-1:0] USABLE_V = STW'(SUBFRAME_BYTES - usable_slack(l));
    localparam logic [STW-1:0] SB_V     = STW'(SUBFRAME_BYTES);
    localparam logic [STW-1:0] BASE_V   = STW'(GROUP_AREA_BASE);

    logic [5:0]     off_q, off_d;
    logic [STW-1:0] start_q, start_d;
    logic [STW-1:0] start_end;
    logic [3:0]     quo;
    logic [2:0]     rem;

    assign start_end = start_q + GS_V;
    assign quo       = div6(off_q);
    assign rem       = mod6(off_q);

    always_comb begin
      lane_info[l-1].in_group = (start_q < USABLE_V) && (start_end <= SB_V);
      lane_info[l-1].iq_done  = (off_q < 6'(6 * l)) && (rem == 3'd5);
      lane_info[l-1].mic_done = (off_q == 6'(6 * l + 1));
      lane_info[l-1].rx       = quo[2:0];
    end

    always_comb begin
      off_d   = off_q;
      start_d = start_q;
      if (ctrl_i.restart) begin
        off_d   = '0;
        start_d = BASE_V;
      end else if (ctrl_i.advance) begin
        if (off_q == 6'(GS - 1)) begin
          off_d   = '0;
          start_d = start_end;
        end else begin
          off_d = off_q + 6'd1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        off_q   <= '0;
        start_q <= '0;
      end else begin
        off_q   <= off_d;
        start_q <= start_d;
      end
    end
  end

  always_comb begin
    grp_o = '0;
    for (int l = 1; l <= MAX_RECEIVERS; l++) begin
      if (rx_count_i == 4'(l)) begin
        grp_o = lane_info[l-1];
      end
    end
  end

endmodule

### rtl/core/rpsd_parser.sv
`timescale 1ns / 1ps
module rpsd_parser #(
  parameter int SUBFRAME_BYTES = 512,
  parameter int MAX_RECEIVERS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rpsd_pkg::in_item_t   item_i,
  input  logic [3:0]          rx_count_i,
  input  logic [7:0]          sync_byte_i,
  output logic                res_valid_o,
  output rpsd_pkg::out_item_t  res_o,
  output rpsd_pkg::par_stat_t  stat_o
);
  import rpsd_pkg::*;

  localparam int CAP = HDR_BYTES + 2 * SUBFRAME_BYTES;
  localparam int PPW = $clog2(CAP + 1);
  localparam int SPW = $clog2(SUBFRAME_BYTES);

  localparam logic [PPW-1:0] CAP_V = PPW'(CAP);
  localparam logic [PPW-1:0] HDR_V = PPW'(HDR_BYTES);
  localparam logic [SPW:0]   SB_V  = (SPW+1)'(SUBFRAME_BYTES);

  logic [PPW-1:0] pp_q, pp_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [47:0]    acc_q, acc_d;
  logic [7:0]     ep_q, ep_d;
  logic [31:0]    seq_q, seq_d;
  logic           drop_q, drop_d;
  logic           halt_q, halt_d;

  logic [7:0]     b;
  logic [47:0]    acc_sh;
  logic [SPW:0]   sp_inc;
  logic           work;
  lane_ctrl_t     lctrl;
  grp_info_t      grp;

  assign b      = item_i.data_byte;
  assign acc_sh = {acc_q[39:0], b};
  assign sp_inc = {1'b0, sp_q} + (SPW+1)'(1);
  assign work   = step_i && !halt_q && !drop_q && (pp_q < CAP_V);

  always_comb begin
    lctrl.restart = work && (pp_q >= HDR_V) && (sp_q == SPW'(CTRL_LAST));
    lctrl.advance = work && (pp_q >= HDR_V) && (sp_q >= SPW'(GROUP_AREA_BASE));
  end

  rpsd_group_lanes #(
    .SUBFRAME_BYTES (SUBFRAME_BYTES),
    .MAX_RECEIVERS  (MAX_RECEIVERS),
    .SPW            (SPW)
  ) u_lanes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lctrl),
    .rx_count_i (rx_count_i),
    .grp_o      (grp)
  );

  always_comb begin
    pp_d        = pp_q;
    sp_d        = sp_q;
    acc_d       = acc_q;
    ep_d        = ep_q;
    seq_d       = seq_q;
    drop_d      = drop_q;
    halt_d      = halt_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (work) begin
      if (pp_q < HDR_V) begin
        case (pp_q[2:0])
          3'd0: begin
            acc_d = {40'd0, b};
          end
          3'd1: begin
            if (acc_q != {40'd0, HDR_MAGIC0} || b != HDR_MAGIC1) begin
              drop_d             = 1'b1;
              res_valid_o        = 1'b1;
              res_o.result_kind  = KIND_ERROR;
              res_o.error_code   = ERR_BAD_HEADER;
            end
          end
          3'd2: begin
            if (b == PKT_TYPE_DISC_A || b == PKT_TYPE_DISC_B) begin
              drop_d = 1'b1;
            end else if (b != PKT_TYPE_DATA) begin
              halt_d            = 1'b1;
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_BAD_PKT_TYPE;
              res_o.halted      = 1'b1;
            end
          end
          3'd3: begin
            ep_d  = b;
            seq_d = '0;
          end
          default: begin
            seq_d = {seq_q[23:0], b};
            if (pp_q[2:0] == 3'd7) begin
              sp_d                  = '0;
              acc_d                 = '0;
              res_valid_o           = 1'b1;
              res_o.endpoint        = ep_q;
              res_o.sequence_number = seq_d;
              if (ep_q == EP_SAMPLES || ep_q == EP_IGNORED) begin
                if (ep_q == EP_IGNORED) begin
                  drop_d = 1'b1;
                end
                res_o.result_kind = KIND_HEADER;
              end else begin
                halt_d            = 1'b1;
                res_o.result_kind = KIND_ERROR;
                res_o.error_code  = ERR_BAD_ENDPOINT;
                res_o.halted      = 1'b1;
              end
            end
          end
        endcase
      end else begin
        sp_d = (sp_inc >= SB_V) ? '0 : sp_inc[SPW-1:0];
        if (sp_q < SPW'(SYNC_BYTES)) begin
          if (b != sync_byte_i) begin
            halt_d                = 1'b1;
            res_valid_o           = 1'b1;
            res_o.result_kind     = KIND_ERROR;
            res_o.endpoint        = ep_q;
            res_o.sequence_number = seq_q;
            res_o.error_code      = ERR_SYNC;
            res_o.halted          = 1'b1;
          end
        end else if (sp_q < SPW'(GROUP_AREA_BASE)) begin
          acc_d = acc_sh;
          if (sp_q == SPW'(CTRL_LAST)) begin
            acc_d               = '0;
            res_valid_o         = 1'b1;
            res_o.result_kind   = KIND_CONTROL;
            res_o.control_bytes = acc_sh[39:0];
          end
        end else if (grp.in_group) begin
          acc_d = acc_sh;
          if (grp.iq_done) begin
            res_valid_o          = 1'b1;
            res_o.result_kind    = KIND_IQ;
            res_o.receiver_index = grp.rx;
            res_o.i_sample       = acc_sh[47:24];
            res_o.q_sample       = acc_sh[23:0];
          end else if (grp.mic_done) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = KIND_MIC;
            res_o.mic_sample  = acc_sh[15:0];
          end
        end
      end
    end

    if (step_i && !halt_q) begin
      if (pp_q < CAP_V) begin
        pp_d = pp_q + PPW'(1);
      end
      if (item_i.end_of_datagram && !halt_d) begin
        pp_d   = '0;
        sp_d   = '0;
        acc_d  = '0;
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      sp_q   <= '0;
      acc_q  <= '0;
      ep_q   <= '0;
      seq_q  <= '0;
      drop_q <= 1'b0;
      halt_q <= 1'b0;
    end else begin
      pp_q   <= pp_d;
      sp_q   <= sp_d;
      acc_q  <= acc_d;
      ep_q   <= ep_d;
      seq_q  <= seq_d;
      drop_q <= drop_d;
      halt_q <= halt_d;
    end
  end

  always_comb begin
    stat_o.halted    = halt_q;
    stat_o.drop_rest = drop_q;
  end

endmodule

### rtl/core/radio_packet_sample_deframer_core.sv
`timescale 1ns / 1ps
// Sample stream deframer: takes datagram payload one byte per transfer, with
// end_of_datagram on the last byte, checks the 8-byte packet header and emits
// a header result, then splits each sub-frame of endpoint 6 into its control
// bytes, one I/Q result per receiver and a mic result per sample group. Bad
// header magic drops the datagram with a non-fatal error; a bad packet type,
// an endpoint other than 4 or 6, or a sync mismatch emits a fatal error and
// the core then discards every byte until reset. Each byte is held in the input
// register and its result in the result register; throughput is one byte per
// cycle while the receiver does not stall the output. Configuration writes
// apply to bytes that reach the parser afterward.
module radio_packet_sample_deframer_core #(
  parameter int SUBFRAME_BYTES = 512,
  parameter int MAX_RECEIVERS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rpsd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rpsd_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import rpsd_pkg::*;
  `include "radio_packet_sample_deframer_core_macros.svh"

  // Configuration registers
  logic [3:0] rx_count_q;
  logic [7:0] sync_byte_q;
  logic [3:0] rx_eff;

  // Input and result registers
  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q;
  logic       out_vld_q;

  logic       advance;
  logic       in_xfer;
  logic       par_valid;
  out_item_t  par_res;
  par_stat_t  par_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q  <= RX_COUNT_RESET;
      sync_byte_q <= SYNC_BYTE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RECEIVER_COUNT: rx_count_q  <= cfg_data_i[3:0];
        CFG_SYNC_BYTE:      sync_byte_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the receiver count: zero counts as one, and cap at eight and at the lane count.
  always_comb begin
    rx_eff = rx_count_q;
    if (rx_eff == 4'd0) begin
      rx_eff = 4'd1;
    end
    if (rx_eff > RX_COUNT_LIMIT) begin
      rx_eff = RX_COUNT_LIMIT;
    end
    if (rx_eff > 4'(MAX_RECEIVERS)) begin
      rx_eff = 4'(MAX_RECEIVERS);
    end
  end

  // Advance the held byte whenever the result register is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  rpsd_parser #(
    .SUBFRAME_BYTES (SUBFRAME_BYTES),
    .MAX_RECEIVERS  (MAX_RECEIVERS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .rx_count_i  (rx_eff),
    .sync_byte_i (sync_byte_q),
    .res_valid_o (par_valid),
    .res_o       (par_res),
    .stat_o      (par_stat)
  );

  // Load a new result, or drop the old one once its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && par_valid) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && par_valid) begin
      out_q <= par_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A halted parser never produces another result.
  `RPSD_ASSERT_MSG(a_halt_silent, par_stat.halted |-> !par_valid, "result after halt")
  // Only fatal errors carry the halted flag.
  `RPSD_ASSERT_MSG(a_halt_kind,
    out_vld_q && out_q.halted |->
      out_q.result_kind == KIND_ERROR && out_q.error_code != ERR_BAD_HEADER,
    "halted flag on a non-fatal result")
  // A fresh result always comes from a byte that advanced out of the input register.
  `RPSD_ASSERT(a_load_source, $rose(out_vld_q) |-> $past(advance) && $past(par_valid))

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rpsd_pkg::*;

  localparam int SF_BYTES = 512;
  localparam int MAX_RX = 8;
  localparam int PKT_CAP = HDR_BYTES + 2 * SF_BYTES;
  localparam int IQ_BYTES = 6;
  // Random-phase byte budget; directed rows and the closing fatal and trailing packets add the rest.
  localparam int RANDOM_ITEMS = 900;
  localparam int SETTLE_LIMIT = 2000;
  // Lets the input and result registers empty for bytes that produce nothing.
  localparam int DRAIN_CYCLES = 8;
  localparam out_item_t NO_RESULT = '0;
  // Tail of each sub-frame that carries no sample groups, per receiver count.
  localparam int SLACK_BY_RX [9] = '{0, 0, 0, 4, 10, 24, 10, 20, 4};
  localparam logic [7:0] CORNER [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};

  typedef enum {
    DG_SAMPLES, DG_IGNORED_EP, DG_DISCOVERY, DG_BAD_MAGIC, DG_CUT_HEADER,
    DG_BAD_TYPE, DG_BAD_EP, DG_BAD_SYNC
  } dgram_e;

  // One directed byte; "typed" rows carry their expected result inline.
  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       typed;
    out_item_t  want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_idx = CFG_RECEIVER_COUNT;
  logic [7:0] cfg_data = '0;

  // Deframer shadow state, kept in step with every accepted byte.
  int          pkt_pos = 0;
  int          sub_pos = 0;
  logic [47:0] acc_q = '0;
  logic [7:0]  hdr_ep = '0;
  logic [31:0] hdr_seq = '0;
  bit          drop_q = 1'b0;
  bit          halted_q = 1'b0;
  logic [3:0]  rx_count_q = RX_COUNT_RESET;
  logic [7:0]  sync_q = SYNC_BYTE_RESET;
  int          sent_items = 0;

  stim_row_t dir_rows [$];
  out_item_t pending_results [$];
  int        fault_count = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  radio_packet_sample_deframer_core #(
    .SUBFRAME_BYTES(SF_BYTES),
    .MAX_RECEIVERS (MAX_RX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back-to-back, some short gaps, a few long ones; none while calm.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input logic [7:0] data, input logic eod,
                                  input logic typed, input out_item_t want);
    stim_row_t row;
    row = '{data, eod, typed, want};
    dir_rows = {dir_rows, row};
  endfunction

  function automatic out_item_t halt_with(input logic [1:0] code, input logic [7:0] ep,
                                          input logic [31:0] seq);
    out_item_t r;
    r = '0;
    halted_q = 1'b1;
    r.result_kind = KIND_ERROR;
    r.endpoint = ep;
    r.sequence_number = seq;
    r.error_code = code;
    r.halted = 1'b1;
    return r;
  endfunction

  // Advance the shadow deframer by one byte; return 1 when it yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, input logic eod,
                                      output out_item_t r);
    bit fired;
    int sp, rx, gs, k, off, start;
    r = '0;
    fired = 1'b0;
    if (halted_q) return 1'b0;
    if (!drop_q && pkt_pos < PKT_CAP) begin
      if (pkt_pos < HDR_BYTES) begin
        case (pkt_pos)
          0: acc_q = {40'd0, b};
          1: begin
            if (acc_q[7:0] != HDR_MAGIC0 || b != HDR_MAGIC1) begin
              drop_q = 1'b1;
              r.result_kind = KIND_ERROR;
              r.error_code = ERR_BAD_HEADER;
              fired = 1'b1;
            end
          end
          2: begin
            if (b == PKT_TYPE_DISC_A || b == PKT_TYPE_DISC_B) begin
              drop_q = 1'b1;
            end else if (b != PKT_TYPE_DATA) begin
              r = halt_with(ERR_BAD_PKT_TYPE, '0, '0);
              fired = 1'b1;
            end
          end
          3: begin
            hdr_ep = b;
            hdr_seq = '0;
          end
          default: begin
            hdr_seq = {hdr_seq[23:0], b};
            if (pkt_pos == HDR_BYTES - 1) begin
              sub_pos = 0;
              acc_q = '0;
              if (hdr_ep == EP_SAMPLES || hdr_ep == EP_IGNORED) begin
                drop_q = (hdr_ep == EP_IGNORED);
                r.result_kind = KIND_HEADER;
                r.endpoint = hdr_ep;
                r.sequence_number = hdr_seq;
              end else begin
                r = halt_with(ERR_BAD_ENDPOINT, hdr_ep, hdr_seq);
              end
              fired = 1'b1;
            end
          end
        endcase
      end else begin
        sp = sub_pos;
        sub_pos = (sp + 1 >= SF_BYTES) ? 0 : sp + 1;
        if (sp < SYNC_BYTES) begin
          if (b != sync_q) begin
            r = halt_with(ERR_SYNC, hdr_ep, hdr_seq);
            fired = 1'b1;
          end
        end else if (sp <= CTRL_LAST) begin
          acc_q = {acc_q[39:0], b};
          if (sp == CTRL_LAST) begin
            r.result_kind = KIND_CONTROL;
            r.control_bytes = acc_q[39:0];
            acc_q = '0;
            fired = 1'b1;
          end
        end else begin
          // Clamp the receiver count, then locate this byte inside its group.
          rx = (rx_count_q == 4'd0) ? 1 : int'(rx_count_q);
          if (rx > int'(RX_COUNT_LIMIT)) rx = int'(RX_COUNT_LIMIT);
          if (rx > MAX_RX) rx = MAX_RX;
          gs = IQ_BYTES * rx + 2;
          k = sp - GROUP_AREA_BASE;
          off = k % gs;
          start = GROUP_AREA_BASE + (k / gs) * gs;
          if (start < SF_BYTES - SLACK_BY_RX[rx] && start + gs <= SF_BYTES) begin
            acc_q = {acc_q[39:0], b};
            if (off < IQ_BYTES * rx) begin
              if (off % IQ_BYTES == IQ_BYTES - 1) begin
                r.result_kind = KIND_IQ;
                r.receiver_index = 3'(off / IQ_BYTES);
                r.i_sample = acc_q[47:24];
                r.q_sample = acc_q[23:0];
                fired = 1'b1;
              end
            end else if (off == IQ_BYTES * rx + 1) begin
              r.result_kind = KIND_MIC;
              r.mic_sample = acc_q[15:0];
              fired = 1'b1;
            end
          end
        end
      end
    end
    if (pkt_pos < PKT_CAP) pkt_pos++;
    if (eod && !halted_q) begin
      pkt_pos = 0;
      sub_pos = 0;
      acc_q = '0;
      drop_q = 1'b0;
    end
    return fired;
  endfunction

  // Present one byte after a random gap, hold it until the transfer, then
  // queue what the deframer should produce for it.
  task automatic push_byte(input logic [7:0] b, input logic eod, input logic typed,
                           input out_item_t typed_want);
    int gap;
    bit fired;
    out_item_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_datagram: eod};
    do @(posedge clk_i); while (in_stall);
    sent_items++;
    fired = deframe_byte(b, eod, predicted);
    if (typed) pending_results = {pending_results, typed_want};
    else if (fired) pending_results = {pending_results, predicted};
  endtask

  // Stop sending, let every expected result drain, then let the pipe empty.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived, first expected %h", $time,
               pending_results.size(), pending_results[0]);
      fault_count++;
      pending_results.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_RECEIVER_COUNT) rx_count_q = value[3:0];
    else sync_q = value;
    @(posedge clk_i);
  endtask

  // Build one datagram of the given flavor and length and push it byte by byte.
  task automatic send_datagram(input dgram_e kind, input int len);
    logic [7:0] hdr [HDR_BYTES];
    logic [7:0] b;
    int bad_at;
    int sel;
    hdr[0] = HDR_MAGIC0;
    hdr[1] = HDR_MAGIC1;
    hdr[2] = PKT_TYPE_DATA;
    hdr[3] = EP_SAMPLES;
    for (int i = 4; i < HDR_BYTES; i++) hdr[i] = 8'($urandom);
    bad_at = -1;
    case (kind)
      DG_IGNORED_EP: hdr[3] = EP_IGNORED;
      DG_DISCOVERY: begin
        hdr[2] = $urandom_range(0, 1) ? PKT_TYPE_DISC_A : PKT_TYPE_DISC_B;
        hdr[3] = 8'($urandom);
      end
      DG_BAD_MAGIC: begin
        // Keep one magic byte right now and then so each check is hit alone.
        sel = $urandom_range(0, 2);
        hdr[0] = (sel == 0) ? HDR_MAGIC0 : 8'($urandom);
        hdr[1] = (sel == 1) ? HDR_MAGIC1 : 8'($urandom);
        if (hdr[0] == HDR_MAGIC0 && hdr[1] == HDR_MAGIC1) hdr[1] = ~hdr[1];
      end
      DG_BAD_TYPE: begin
        do hdr[2] = 8'($urandom);
        while (hdr[2] == PKT_TYPE_DATA || hdr[2] == PKT_TYPE_DISC_A ||
               hdr[2] == PKT_TYPE_DISC_B);
      end
      DG_BAD_EP: begin
        do hdr[3] = 8'($urandom);
        while (hdr[3] == EP_SAMPLES || hdr[3] == EP_IGNORED);
      end
      DG_BAD_SYNC: bad_at = HDR_BYTES + $urandom_range(0, SYNC_BYTES - 1);
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      if (i < HDR_BYTES) b = hdr[i];
      else if (i < PKT_CAP && (i - HDR_BYTES) % SF_BYTES < SYNC_BYTES)
        b = (i == bad_at) ? ~sync_q : sync_q;
      else if ($urandom_range(0, 7) == 0) b = CORNER[$urandom_range(0, 3)];
      else b = 8'($urandom);
      push_byte(b, i == len - 1, 1'b0, NO_RESULT);
    end
  endtask

  // Receiver side: random stall bursts, with stall-free stretches while calm.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Compare every transfer on the result side against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("endpoint", want.endpoint, out_data.endpoint);
        check_field("sequence_number", want.sequence_number, out_data.sequence_number);
        check_field("control_bytes", want.control_bytes, out_data.control_bytes);
        check_field("receiver_index", want.receiver_index, out_data.receiver_index);
        check_field("i_sample", want.i_sample, out_data.i_sample);
        check_field("q_sample", want.q_sample, out_data.q_sample);
        check_field("mic_sample", want.mic_sample, out_data.mic_sample);
        check_field("error_code", want.error_code, out_data.error_code);
        check_field("halted", want.halted, out_data.halted);
      end
    end
  end

  initial begin : stimulus
    out_item_t bad_hdr, hdr6, ctrl6, iq6;
    dgram_e kind;
    int roll, len, rx_val, start_items;
    logic [7:0] sync_val;

    bad_hdr = '0;
    bad_hdr.result_kind = KIND_ERROR;
    bad_hdr.error_code = ERR_BAD_HEADER;
    hdr6 = '0;
    hdr6.result_kind = KIND_HEADER;
    hdr6.endpoint = EP_SAMPLES;
    hdr6.sequence_number = 32'h1234_5678;
    ctrl6 = '0;
    ctrl6.result_kind = KIND_CONTROL;
    ctrl6.control_bytes = 40'hFF_00FF_00FF;
    iq6 = '0;
    iq6.result_kind = KIND_IQ;
    iq6.i_sample = 24'h80_0000;
    iq6.q_sample = 24'h7F_FFFF;

    // Bad magic: error on the second byte, which also ends the datagram.
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b1, 1'b1, bad_hdr);
    // Discovery packet: dropped silently.
    add_row(HDR_MAGIC0, 1'b0, 1'b0, NO_RESULT);
    add_row(HDR_MAGIC1, 1'b0, 1'b0, NO_RESULT);
    add_row(PKT_TYPE_DISC_B, 1'b1, 1'b0, NO_RESULT);
    // Sample packet at reset settings, cut short after the first I/Q pair.
    add_row(HDR_MAGIC0, 1'b0, 1'b0, NO_RESULT);
    add_row(HDR_MAGIC1, 1'b0, 1'b0, NO_RESULT);
    add_row(PKT_TYPE_DATA, 1'b0, 1'b0, NO_RESULT);
    add_row(EP_SAMPLES, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h12, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h34, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h56, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h78, 1'b0, 1'b1, hdr6);
    repeat (SYNC_BYTES) add_row(SYNC_BYTE_RESET, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b1, ctrl6);
    // Most negative I, most positive Q.
    add_row(8'h80, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h7F, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b1, 1'b1, iq6);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      push_byte(dir_rows[i].data, dir_rows[i].eod, dir_rows[i].typed, dir_rows[i].want);

    // Random phases: reprogram both registers while idle, then a few datagrams.
    start_items = sent_items;
    while (sent_items - start_items < RANDOM_ITEMS) begin
      settle();
      roll = $urandom_range(0, 4);
      case (roll)
        0: rx_val = 0;
        1: rx_val = 1;
        2: rx_val = 8;
        3: rx_val = 15;
        default: rx_val = $urandom_range(0, 15);
      endcase
      write_reg(CFG_RECEIVER_COUNT, {4'($urandom), 4'(rx_val)});
      roll = $urandom_range(0, 3);
      sync_val = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom);
      write_reg(CFG_SYNC_BYTE, sync_val);
      repeat ($urandom_range(1, 4)) begin
        if (sent_items - start_items < RANDOM_ITEMS) begin
          calm = ($urandom_range(0, 4) == 0);
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            // Mostly short sample packets; some run through both sub-frames.
            kind = DG_SAMPLES;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(480, PKT_CAP + 28)
                                              : $urandom_range(9, 160);
          end else if (roll < 78) begin
            kind = DG_IGNORED_EP;
            len = $urandom_range(8, 30);
          end else if (roll < 86) begin
            kind = DG_DISCOVERY;
            len = $urandom_range(3, 30);
          end else if (roll < 95) begin
            kind = DG_BAD_MAGIC;
            len = $urandom_range(1, 20);
          end else begin
            kind = DG_CUT_HEADER;
            len = $urandom_range(1, HDR_BYTES - 1);
          end
          send_datagram(kind, len);
        end
      end
    end

    // One fatal error closes the run; the trailing packet must vanish.
    settle();
    calm = 1'b0;
    case ($urandom_range(0, 2))
      0: kind = DG_BAD_TYPE;
      1: kind = DG_BAD_EP;
      default: kind = DG_BAD_SYNC;
    endcase
    send_datagram(kind, $urandom_range(20, 40));
    send_datagram(DG_SAMPLES, 60);
    settle();

    if (fault_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
